[hw/rtl/swtq_pkg.sv]
`timescale 1ns / 1ps

package swtq_pkg;

    localparam int TIME_W = 64;
    localparam int ID_W   = 8;
    localparam int TICK_W = 32;

    // Input mode codes
    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Result status codes
    localparam logic STATUS_WOKEN  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[hw/rtl/swtq_ram.sv]
`timescale 1ns / 1ps

module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // registered read; data holds while no read is issued
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/sorted_wakeup_timer_queue.sv]
`timescale 1ns / 1ps

// Sleep: a positive request walks the queue from the tail, moving each later entry up a
// slot, one RAM read each; a non-positive request is ignored, a full queue gets a reject.
// Tick: advances time; on a non-empty queue it wakes each due task, one RAM read each;
// results leave through one output register, and a stalled result holds the walk.
// One item at a time; a new item is taken once the previous one is finished.
// Reset clears the tick counter, queue pointers and output register; the RAM is not cleared.

module sorted_wakeup_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [swtq_pkg::ID_W-1:0]        s_task_id,
    input  logic signed [swtq_pkg::TICK_W-1:0] s_sleep_ticks,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [swtq_pkg::ID_W-1:0]        m_woken_id,
    output logic                             m_status,
    output logic                             m_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);      // RAM address width
    localparam int CW = $clog2(QUEUE_DEPTH + 1);  // fill count width
    localparam int SW = AW + 2;                   // head + count sum width

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_RD   = 3'd1;
    localparam logic [2:0] ST_INS_CMP  = 3'd2;
    localparam logic [2:0] ST_TK_CMP   = 3'd3;
    localparam logic [2:0] ST_TK_FLUSH = 3'd4;
    localparam logic [2:0] ST_REJ      = 3'd5;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [swtq_pkg::TIME_W-1:0] now_reg, now_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          m_valid_reg, m_valid_next;

    // Working registers
    logic [AW-1:0] cur_reg, cur_next;          // slot being filled during insert
    logic [CW-1:0] left_reg, left_next;        // entries still above the insert slot
    logic [swtq_pkg::TIME_W-1:0] when_reg, when_next;
    logic [swtq_pkg::ID_W-1:0]   new_id_reg, new_id_next;
    logic [swtq_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [swtq_pkg::ID_W-1:0]   m_id_reg, m_id_next;
    logic          m_status_reg, m_status_next;
    logic          m_last_reg, m_last_next;

    // RAM port
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    swtq_pkg::entry_t ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [swtq_pkg::ENTRY_W-1:0] ram_rd_raw;
    swtq_pkg::entry_t ram_rd;

    logic          out_free;
    logic          sleep_pos;
    logic          due;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_idx;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] cur_dec;
    logic [AW-1:0] cur_dec2;
    logic [CW-1:0] left_dec;
    logic [CW-1:0] count_dec;

    swtq_ram #(
        .WIDTH (swtq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign ram_rd = swtq_pkg::entry_t'(ram_rd_raw);

    // Circular-buffer index arithmetic; depth need not be a power of two
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
        idx_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
        idx_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    endfunction

    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_idx  = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : tail_sum[AW-1:0];
    assign head_inc  = idx_inc(head_reg);
    assign cur_dec   = idx_dec(cur_reg);
    assign cur_dec2  = idx_dec(cur_dec);
    assign left_dec  = left_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);

    // Output register can take a new item this cycle
    assign out_free  = !m_valid_reg || m_ready;
    // Positive sleep: sign clear and not zero
    assign sleep_pos = !s_sleep_ticks[swtq_pkg::TICK_W-1] && (s_sleep_ticks != '0);
    // Head entry last read from the RAM has come due
    assign due       = (ram_rd.wake <= now_reg);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_woken_id = m_id_reg;
    assign m_status   = m_status_reg;
    assign m_last     = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        cur_next        = cur_reg;
        left_next       = left_reg;
        when_next       = when_reg;
        new_id_next     = new_id_reg;

        // drop the held result once taken
        m_valid_next    = m_valid_reg && !m_ready;
        m_id_next       = m_id_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;

        ram_wr_en       = 1'b0;
        ram_wr_addr     = cur_reg;
        ram_wr_data     = '{wake: when_reg, id: new_id_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = cur_dec;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == swtq_pkg::MODE_TICK) begin
                        // advance time, then look at the head (earliest) entry
                        now_next        = now_reg + swtq_pkg::TIME_W'(1);
                        pend_valid_next = 1'b0;
                        if (count_reg != '0) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                            state_next  = ST_TK_CMP;
                        end
                    end else if (sleep_pos) begin
                        new_id_next = s_task_id;
                        if (count_reg == CW'(QUEUE_DEPTH)) begin
                            state_next = ST_REJ;
                        end else begin
                            when_next  = now_reg + swtq_pkg::TIME_W'(unsigned'(s_sleep_ticks));
                            cur_next   = tail_idx;
                            left_next  = count_reg;
                            state_next = ST_INS_RD;
                        end
                    end
                end
            end

            ST_INS_RD: begin
                if (left_reg == '0) begin
                    // insert slot found at the head end
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_dec;
                    state_next  = ST_INS_CMP;
                end
            end

            ST_INS_CMP: begin
                ram_wr_en = 1'b1;
                if (ram_rd.wake > when_reg) begin
                    // move the later entry up one slot and keep walking
                    ram_wr_data = ram_rd;
                    cur_next    = cur_dec;
                    left_next   = left_dec;
                    if (left_dec == '0) begin
                        state_next = ST_INS_RD;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_dec2;
                    end
                end else begin
                    // equal or earlier time: new entry goes behind it
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_TK_CMP: begin
                // hold while a pending result cannot be placed
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_id_next     = pend_id_reg;
                        m_status_next = swtq_pkg::STATUS_WOKEN;
                        m_last_next   = !due;
                    end
                    if (due) begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = ram_rd.id;
                        head_next       = head_inc;
                        count_next      = count_dec;
                        if (count_dec == '0) begin
                            state_next = ST_TK_FLUSH;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_inc;
                        end
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            ST_TK_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_id_next       = pend_id_reg;
                    m_status_next   = swtq_pkg::STATUS_WOKEN;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_REJ: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_id_next     = new_id_reg;
                    m_status_next = swtq_pkg::STATUS_REJECT;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload and working registers need no reset
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        left_reg     <= left_next;
        when_reg     <= when_next;
        new_id_reg   <= new_id_next;
        pend_id_reg  <= pend_id_next;
        m_id_reg     <= m_id_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

endmodule

[hw/rtl/swtq_checker.sv]
`timescale 1ns / 1ps

module swtq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_mode,
    input logic [swtq_pkg::ID_W-1:0]          s_task_id,
    input logic signed [swtq_pkg::TICK_W-1:0] s_sleep_ticks,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [swtq_pkg::ID_W-1:0]          m_woken_id,
    input logic                               m_status,
    input logic                               m_last
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_woken_id) && $stable(m_status)
                                && $stable(m_last))
        else $error("result changed while stalled");

    // A reject is always the only result of its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == swtq_pkg::STATUS_REJECT) |-> m_last)
        else $error("reject without last");

    // Reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A non-positive sleep request leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == swtq_pkg::MODE_SLEEP)
        && (s_sleep_ticks <= 0) |=> s_ready)
        else $error("ignored sleep request kept the block busy");

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_swtq_checker (.*);
